/* rtl/core/cfae_pkg.sv */
// Shared constants, types and the hex digit function of the CAN frame ASCII encoder.
`timescale 1ns / 1ps
package cfae_pkg;

	localparam int MAX_DATA_BYTES = 8;
	localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

	localparam int IN_DATA_W = 104;
	localparam int IN_USER_W = 3;
	localparam int OUT_DATA_W = 8;

	localparam logic [15:0] TS_WRAP_LIMIT = 16'd59999;

	localparam logic [7:0] CH_DIGIT_BASE = 8'd48;
	localparam logic [7:0] CH_ALPHA_BASE = 8'd55;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_TAG_STD_DATA = 8'h74;
	localparam logic [7:0] CH_TAG_STD_RTR = 8'h72;
	localparam logic [7:0] CH_TAG_EXT_DATA = 8'h54;
	localparam logic [7:0] CH_TAG_EXT_RTR = 8'h52;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} beat_t;

	typedef struct packed {
		logic        extended;
		logic        remote;
		logic [28:0] ident;
		logic [3:0]  length;
		logic [63:0] payload;
	} frame_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return CH_DIGIT_BASE + {4'b0000, nib};
		end else begin
			return CH_ALPHA_BASE + {4'b0000, nib};
		end
	endfunction

endpackage

/* rtl/core/can_frame_ascii_encoder_unit.sv */
// Top level of the CAN frame ASCII encoder.
//
// The slave stream carries one item per beat: s_tuser bit 0 selects a millisecond
// tick (1) or a received frame (0). A tick advances the timestamp and produces no
// output. A frame produces one ASCII line on the master stream, one character per
// beat, with m_tlast set on the closing carriage return.
// A line holds N characters, from 6 to 31. A frame occupies the sequencer from the load
// on; it then gives one hex digit per cycle from the identifier, data and timestamp
// shift registers, while the output register can take it. A tick leaves the sequencer idle.
// The first character of a frame passes the sequencer state and then the output register.
// s_tready is high only while the sequencer is idle.
// The cfg port writes the timestamp enable bit and is always ready; write it only
// while no line is being produced.
// An output register sits before the master stream. When m_tready is low the
// register holds its beat and the sequencer waits, so no character is lost.
// Reset clears the timestamp to zero, the timestamp enable to off, and empties
// the sequencer and the output register.
`timescale 1ns / 1ps
module can_frame_ascii_encoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// ident[28:0], length[32:29], payload[96:33], zero fill above.
	input  logic [cfae_pkg::IN_DATA_W-1:0] s_tdata,
	// action[0], extended[1], remote[2].
	input  logic [cfae_pkg::IN_USER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// character[7:0].
	output logic [cfae_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                          m_tlast
);
	import cfae_pkg::*;

	logic        ts_enable_q;
	logic        out_valid_q;
	beat_t       out_beat_q;
	logic        s_beat;
	logic        tick;
	logic        start;
	logic        adv;
	logic        fmt_idle;
	logic        fmt_valid;
	beat_t       fmt_beat;
	logic [15:0] ts_count;
	frame_t      frame;

	assign cfg_ready = 1'b1;
	assign s_tready  = fmt_idle;
	assign s_beat    = s_tvalid & s_tready;
	assign tick      = s_beat & s_tuser[0];
	assign start     = s_beat & ~s_tuser[0];
	assign adv       = ~out_valid_q | m_tready;

	assign frame.extended = s_tuser[1];
	assign frame.remote   = s_tuser[2];
	assign frame.ident    = s_tdata[28:0];
	assign frame.length   = s_tdata[32:29];
	assign frame.payload  = s_tdata[96:33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			ts_enable_q <= cfg_data;
		end
	end

	cfae_tstamp u_tstamp (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.count  (ts_count)
	);

	cfae_fmt u_fmt (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.frame      (frame),
		.ts_enable  (ts_enable_q),
		.ts_value   (ts_count),
		.adv        (adv),
		.idle       (fmt_idle),
		.beat_valid (fmt_valid),
		.beat       (fmt_beat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fmt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fmt_valid) begin
			out_beat_q <= fmt_beat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_beat_q.character;
	assign m_tlast  = out_beat_q.last;

endmodule

/* rtl/core/cfae_tstamp.sv */
// Millisecond timestamp counter that wraps from 59999 to 0.
`timescale 1ns / 1ps
module cfae_tstamp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick,
	output logic [15:0] count
);
	import cfae_pkg::*;

	logic [15:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (tick) begin
			if (count_q >= TS_WRAP_LIMIT) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + 16'd1;
			end
		end
	end

	assign count = count_q;

endmodule

/* rtl/core/cfae_fmt.sv */
// Line sequencer: shifts identifier, data and timestamp out one hex digit per beat.
`timescale 1ns / 1ps
module cfae_fmt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  cfae_pkg::frame_t frame,
	input  logic            ts_enable,
	input  logic [15:0]     ts_value,
	input  logic            adv,
	output logic            idle,
	output logic            beat_valid,
	output cfae_pkg::beat_t beat
);
	import cfae_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TAG  = 3'd1;
	localparam logic [2:0] ST_ID   = 3'd2;
	localparam logic [2:0] ST_LEN  = 3'd3;
	localparam logic [2:0] ST_DATA = 3'd4;
	localparam logic [2:0] ST_TS   = 3'd5;
	localparam logic [2:0] ST_CR   = 3'd6;

	logic [2:0]  state_q;
	logic [4:0]  cnt_q;
	logic [31:0] id_q;
	logic [63:0] pay_q;
	logic [15:0] ts_q;
	logic [7:0]  tag_q;
	logic [3:0]  len_q;
	logic [4:0]  dn_q;
	logic        tsen_q;

	logic [3:0]  len_sat;
	logic [63:0] pay_swap;
	logic [7:0]  tag_sel;

	always_comb begin
		len_sat = (frame.length > MAX_LEN) ? MAX_LEN : frame.length;
		for (int b = 0; b < 8; b++) begin
			pay_swap[8*b +: 8] = {frame.payload[8*b +: 4], frame.payload[8*b+4 +: 4]};
		end
		if (frame.extended) begin
			tag_sel = frame.remote ? CH_TAG_EXT_RTR : CH_TAG_EXT_DATA;
		end else begin
			tag_sel = frame.remote ? CH_TAG_STD_RTR : CH_TAG_STD_DATA;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			id_q   <= frame.extended ? {3'b000, frame.ident} : {frame.ident[11:0], 20'h00000};
			pay_q  <= pay_swap;
			ts_q   <= ts_value;
			tag_q  <= tag_sel;
			len_q  <= len_sat;
			dn_q   <= frame.remote ? 5'd0 : {len_sat, 1'b0};
			tsen_q <= ts_enable;
		end else if (adv) begin
			if (state_q == ST_ID) begin
				id_q <= {id_q[27:0], 4'h0};
			end
			if (state_q == ST_DATA) begin
				pay_q <= {4'h0, pay_q[63:4]};
			end
			if (state_q == ST_TS) begin
				ts_q <= {ts_q[11:0], 4'h0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else if (start) begin
			state_q <= ST_TAG;
			cnt_q   <= frame.extended ? 5'd7 : 5'd2;
		end else if (adv) begin
			unique case (state_q)
				ST_IDLE: begin
					state_q <= ST_IDLE;
				end
				ST_TAG: begin
					state_q <= ST_ID;
				end
				ST_ID: begin
					if (cnt_q == 5'd0) begin
						state_q <= ST_LEN;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_LEN: begin
					if (dn_q != 5'd0) begin
						state_q <= ST_DATA;
						cnt_q   <= dn_q - 5'd1;
					end else if (tsen_q) begin
						state_q <= ST_TS;
						cnt_q   <= 5'd3;
					end else begin
						state_q <= ST_CR;
					end
				end
				ST_DATA: begin
					if (cnt_q != 5'd0) begin
						cnt_q <= cnt_q - 5'd1;
					end else if (tsen_q) begin
						state_q <= ST_TS;
						cnt_q   <= 5'd3;
					end else begin
						state_q <= ST_CR;
					end
				end
				ST_TS: begin
					if (cnt_q == 5'd0) begin
						state_q <= ST_CR;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_CR: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		beat.last = 1'b0;
		unique case (state_q)
			ST_TAG:  beat.character = tag_q;
			ST_ID:   beat.character = hex_char(id_q[31:28]);
			ST_LEN:  beat.character = CH_DIGIT_BASE + {4'b0000, len_q};
			ST_DATA: beat.character = hex_char(pay_q[3:0]);
			ST_TS:   beat.character = hex_char(ts_q[15:12]);
			ST_CR: begin
				beat.character = CH_CR;
				beat.last      = 1'b1;
			end
			default: beat.character = CH_CR;
		endcase
	end

	assign idle       = (state_q == ST_IDLE);
	assign beat_valid = (state_q != ST_IDLE);

endmodule

/* rtl/core/cfae_chk.sv */
// Port-level assertion checker for the CAN frame ASCII encoder, with its bind.
`timescale 1ns / 1ps
module cfae_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [cfae_pkg::IN_USER_W-1:0] s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [cfae_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast
);
	import cfae_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("Stalled output beat changed.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] |=> !s_tready)
		else $error("Input taken while a line is in progress.");

	a_cr_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == CH_CR)
		else $error("Last beat is not a carriage return.");

	a_cr_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata != CH_CR)
		else $error("Carriage return inside a line.");

endmodule

bind can_frame_ascii_encoder_unit cfae_chk u_cfae_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

/* tb/can_frame_ascii_encoder_checker.sv */
// Checker that predicts every ASCII line of the CAN frame encoder and compares each output beat.
`timescale 1ns / 1ps
module can_frame_ascii_encoder_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic                            cfg_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// ident[28:0], length[32:29], payload[96:33], zero fill above.
	input  logic [cfae_pkg::IN_DATA_W-1:0]  s_tdata,
	// action[0], extended[1], remote[2].
	input  logic [cfae_pkg::IN_USER_W-1:0]  s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// character[7:0].
	input  logic [cfae_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            m_tlast,
	output int                              mismatches,
	output int                              chars_owed
);
	import cfae_pkg::*;

	localparam logic [127:0] HEX_ASCII = "FEDCBA9876543210";

	beat_t       line_q[$];
	logic [15:0] ms_count;
	logic        stamp_on;

	initial begin
		mismatches = 0;
		chars_owed = 0;
	end

	function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
		return HEX_ASCII[8*nib +: 8];
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic push_char(input logic [7:0] ch, input logic last);
		beat_t b;
		b.character = ch;
		b.last = last;
		line_q.push_back(b);
	endtask

	task automatic push_hex_byte(input logic [7:0] v);
		push_char(hex_ascii(v[7:4]), 1'b0);
		push_char(hex_ascii(v[3:0]), 1'b0);
	endtask

	// Builds the expected line of one frame from the current timestamp setting and count.
	task automatic encode_frame(input logic ext, input logic rtr, input logic [28:0] id,
		input logic [3:0] len_code, input logic [63:0] bytes);
		logic [3:0]  n_bytes;
		logic [31:0] id_wide;
		n_bytes = (len_code > MAX_LEN) ? MAX_LEN : len_code;
		id_wide = {3'b000, id};
		if (ext) begin
			push_char(rtr ? CH_TAG_EXT_RTR : CH_TAG_EXT_DATA, 1'b0);
			for (int k = 3; k >= 0; k--) begin
				push_hex_byte(id_wide[8*k +: 8]);
			end
		end else begin
			push_char(rtr ? CH_TAG_STD_RTR : CH_TAG_STD_DATA, 1'b0);
			push_char(hex_ascii(id[11:8]), 1'b0);
			push_hex_byte(id[7:0]);
		end
		push_char(CH_DIGIT_BASE + 8'(n_bytes), 1'b0);
		if (!rtr) begin
			for (int k = 0; k < int'(n_bytes); k++) begin
				push_hex_byte(bytes[8*k +: 8]);
			end
		end
		if (stamp_on) begin
			push_hex_byte(ms_count[15:8]);
			push_hex_byte(ms_count[7:0]);
		end
		push_char(CH_CR, 1'b1);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		beat_t want;
		if (!arst_n) begin
			ms_count = '0;
			stamp_on = 1'b0;
			line_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (line_q.size() == 0) begin
					report_mismatch($sformatf("beat with no line pending, char 0x%02h last %0b",
						m_tdata, m_tlast));
				end else begin
					want = line_q.pop_front();
					if (m_tdata !== want.character) begin
						report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
							m_tdata, want.character));
					end
					if (m_tlast !== want.last) begin
						report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
							m_tlast, want.last, want.character));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				stamp_on = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0]) begin
					ms_count = (ms_count >= TS_WRAP_LIMIT) ? 16'd0 : ms_count + 16'd1;
				end else begin
					encode_frame(s_tuser[1], s_tuser[2], s_tdata[28:0], s_tdata[32:29],
						s_tdata[96:33]);
				end
			end
		end
		chars_owed = line_q.size();
	end

endmodule

/* tb/can_frame_ascii_encoder_unit_tb.sv */
// Testbench top that drives frames, ticks and timestamp settings into the CAN frame encoder.
`timescale 1ns / 1ps
module can_frame_ascii_encoder_unit_tb;
	import cfae_pkg::*;

	localparam logic ACT_FRAME = 1'b0;
	localparam logic ACT_TICK = 1'b1;
	localparam int LONG_HOLD = 400;
	localparam int LIMIT_NS = 12_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_data = 1'b0;
	logic                  cfg_ready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	int                    mismatches;
	int                    chars_owed;

	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	int rx_hold = 0;
	int next_gap = 0;

	always #4 clk = ~clk;

	can_frame_ascii_encoder_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	can_frame_ascii_encoder_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.mismatches(mismatches),
		.chars_owed(chars_owed)
	);

	initial begin
		#(LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	// Valid drops only when a gap follows, so back-to-back beats keep it high.
	task automatic send_item(input logic act, input logic ext, input logic rtr,
		input logic [28:0] id, input logic [3:0] len, input logic [63:0] data);
		repeat (next_gap) @(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, data, len, id};
		s_tuser <= {rtr, ext, act};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		next_gap = tx_gaps ? $urandom_range(0, 7) : 0;
		if (next_gap > 0) begin
			s_tvalid <= 1'b0;
		end
	endtask

	task automatic send_random_item(input bit frames_only);
		logic        act;
		logic [3:0]  len;
		logic [63:0] data;
		act = (!frames_only && $urandom_range(0, 3) == 0) ? ACT_TICK : ACT_FRAME;
		len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		data = {$urandom, $urandom};
		send_item(act, 1'($urandom), 1'($urandom_range(0, 3) == 0), 29'($urandom), len, data);
	endtask

	task automatic wait_drained();
		if (next_gap == 0) begin
			s_tvalid <= 1'b0;
		end
		next_gap = 0;
		while (chars_owed != 0) @(negedge clk);
		// Quiet cycles separate the last beat from what follows.
		repeat (4) @(negedge clk);
	endtask

	task automatic write_stamp_enable(input logic on);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= on;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : receiver
		int stall;
		forever begin
			stall = rx_gaps ? $urandom_range(0, 7) : 0;
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Timestamp off from reset: tags, identifier widths, length saturation.
		send_item(ACT_FRAME, 1'b0, 1'b0, 29'h0, 4'd0, 64'h0);
		send_item(ACT_FRAME, 1'b0, 1'b0, 29'h1FFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(ACT_FRAME, 1'b0, 1'b1, 29'h0000_0ABC, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(ACT_FRAME, 1'b1, 1'b0, 29'h1FFF_FFFF, 4'd8, 64'h0123_4567_89AB_CDEF);
		send_item(ACT_FRAME, 1'b1, 1'b1, 29'h0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(ACT_FRAME, 1'b1, 1'b0, 29'h1234_5678, 4'd9, 64'hFEDC_BA98_7654_3210);
		send_item(ACT_FRAME, 1'b0, 1'b0, 29'h1555_5123, 4'd15, 64'hA5A5_5A5A_0FF0_C33C);
		send_item(ACT_FRAME, 1'b0, 1'b1, 29'h1FFF_F800, 4'd0, 64'h0);
		write_stamp_enable(1'b1);
		send_item(ACT_FRAME, 1'b0, 1'b0, 29'h0000_0123, 4'd2, 64'h0000_0000_0000_BEEF);
		send_item(ACT_TICK, 1'b0, 1'b0, 29'h0, 4'd0, 64'h0);
		send_item(ACT_TICK, 1'b1, 1'b1, 29'h1FFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(ACT_TICK, 1'b1, 1'b0, 29'h0ABC_DEF0, 4'd8, 64'h1234_5678_9ABC_DEF0);
		send_item(ACT_FRAME, 1'b1, 1'b0, 29'h0ABC_DEF0, 4'd4, 64'h0000_0000_DEAD_BEEF);
		send_item(ACT_FRAME, 1'b1, 1'b1, 29'h1000_0000, 4'd8, 64'h1111_2222_3333_4444);
		for (int n = 1; n < 8; n++) begin
			send_item(ACT_FRAME, 1'b0, 1'b0, 29'(n * 37), 4'(n), {$urandom, $urandom});
		end

		for (int blk = 0; blk < 9; blk++) begin
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
			if (blk == 2) begin
				// The output side stalls for a long stretch while frames keep coming.
				rx_hold = LONG_HOLD;
				tx_gaps = 1'b0;
				repeat (12) send_random_item(1'b1);
				tx_gaps = 1'b1;
			end
			if (blk == 4) begin
				write_stamp_enable(1'b0);
			end
			if (blk == 6) begin
				write_stamp_enable(1'b1);
			end
			if (blk == 7) begin
				// A tick squeezed between two frames moves the printed timestamp by one.
				tx_gaps = 1'b0;
				send_item(ACT_FRAME, 1'b0, 1'b0, 29'h0000_0555, 4'd1, 64'h0000_0000_0000_0042);
				send_item(ACT_TICK, 1'b0, 1'b0, 29'h0, 4'd0, 64'h0);
				send_item(ACT_FRAME, 1'b1, 1'b1, 29'h0000_0555, 4'd1, 64'h0);
				tx_gaps = 1'b1;
			end
			repeat (40) send_random_item(1'b0);
		end

		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
